/* rtl/core/tww_pkg.sv */
`timescale 1ns / 1ps

package tww_pkg;

	// Automaton capacity
	localparam int MAX_NODES       = 16384;
	localparam int MAX_TRANSITIONS = 32768;

	// Memory address widths and widths of counts that may reach the capacity
	localparam int NAW = $clog2(MAX_NODES);
	localparam int TAW = $clog2(MAX_TRANSITIONS);
	localparam int NCW = $clog2(MAX_NODES + 1);
	localparam int TCW = $clog2(MAX_TRANSITIONS + 1);

	// Field widths
	localparam int MODE_W   = 2;
	localparam int ENTRY_W  = 15;
	localparam int FC_W     = 16;
	localparam int SYM_W    = 8;
	localparam int NODE_W   = 14;
	localparam int NCOUNT_W = 15;
	localparam int TCOUNT_W = 16;

	// Configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_NODE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRANS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEXT  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_EOW   = 2'd3;

	// Register indexes
	localparam logic [1:0] REG_NODE_COUNT  = 2'd0;
	localparam logic [1:0] REG_TRANS_COUNT = 2'd1;
	localparam logic [1:0] REG_ANNOT_SYM   = 2'd2;

	// One stored transition
	typedef struct packed {
		logic [SYM_W-1:0]  symbol;
		logic [NODE_W-1:0] target;
	} trans_t;

endpackage

/* rtl/core/trie_word_walk_unit.sv */
`timescale 1ns / 1ps

// Trie word walk: load items (node start, transition) write the node or
// transition memory and leave the block ready. A text symbol or end-of-word
// item walks one step from the current node: it reads the node's child range
// from the node memory in states S_ST and S_EN, then scans the children at one
// transition per cycle through the single read port of the transition memory.
// The block takes no new item until the scan ends on a match or past the last
// child; a word that has already failed, or a node that is not loaded, leaves
// the block idle.
// End-of-word items return one result (found, node_index) and reset the walk
// to the root; an end of word that finishes while an earlier result still
// waits for the receiver holds the block until that result is taken.
// Memories are not cleared; read only loaded entries.
module trie_word_walk_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tww_pkg::PADDR_W-1:0]      paddr,
	input  logic [tww_pkg::PDATA_W-1:0]      pwdata,
	output logic [tww_pkg::PDATA_W-1:0]      prdata,
	output logic                             pready,
	// input items
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tww_pkg::MODE_W-1:0]       mode,
	input  logic [tww_pkg::ENTRY_W-1:0]      entry_index,
	input  logic [tww_pkg::FC_W-1:0]         first_child,
	input  logic [tww_pkg::SYM_W-1:0]        symbol,
	input  logic [tww_pkg::NODE_W-1:0]       child_node,
	// result items
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             found,
	output logic [tww_pkg::NODE_W-1:0]       node_index
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ST   = 3'd1;
	localparam logic [2:0] S_EN   = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_WAIT = 3'd4;

	logic [2:0]                    state_q;
	logic [tww_pkg::NCOUNT_W-1:0]  node_count_q;
	logic [tww_pkg::TCOUNT_W-1:0]  trans_count_q;
	logic [tww_pkg::SYM_W-1:0]     annot_q;
	logic [tww_pkg::NODE_W-1:0]    cur_q;
	logic                          failed_q;
	logic                          out_valid_q;
	logic                          found_q;
	logic [tww_pkg::NODE_W-1:0]    node_q;
	logic                          wfound_q;
	logic [tww_pkg::NODE_W-1:0]    wnode_q;
	logic [tww_pkg::SYM_W-1:0]     key_q;
	logic                          eow_q;
	logic                          last_q;
	logic                          pend_q;
	logic [tww_pkg::FC_W-1:0]      t_q;
	logic [tww_pkg::TCW-1:0]       end_q;

	logic [tww_pkg::FC_W-1:0]      nmem [tww_pkg::MAX_NODES];
	tww_pkg::trans_t               tmem [tww_pkg::MAX_TRANSITIONS];
	logic [tww_pkg::FC_W-1:0]      nrd_q;
	tww_pkg::trans_t               trd_q;

	logic                          acc;
	logic                          cfg_we;
	logic [1:0]                    reg_idx;
	logic [tww_pkg::NCW-1:0]       nc_eff;
	logic [tww_pkg::TCW-1:0]       tc_eff;
	logic                          cur_oor;
	logic                          cur_last;
	logic [tww_pkg::NAW-1:0]       nrd_addr;
	logic [tww_pkg::TCW-1:0]       end_d;
	logic                          nwe;
	logic                          twe;
	logic                          hit;
	logic                          more;
	logic                          slot_free;
	logic                          fin;
	logic                          fin_found;
	logic [tww_pkg::NODE_W-1:0]    fin_node;
	logic                          out_load;
	tww_pkg::trans_t               twr;

	assign acc       = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign node_index = node_q;
	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_we    = psel && penable && pwrite;

	// Register read-back
	always_comb begin
		unique case (reg_idx)
			tww_pkg::REG_NODE_COUNT:  prdata = tww_pkg::PDATA_W'(node_count_q);
			tww_pkg::REG_TRANS_COUNT: prdata = tww_pkg::PDATA_W'(trans_count_q);
			tww_pkg::REG_ANNOT_SYM:   prdata = tww_pkg::PDATA_W'(annot_q);
			default:                  prdata = '0;
		endcase
	end

	// Clip counts to capacity and classify the current node
	assign nc_eff = (32'(node_count_q) > 32'(tww_pkg::MAX_NODES)) ?
		tww_pkg::NCW'(tww_pkg::MAX_NODES) : tww_pkg::NCW'(node_count_q);
	assign tc_eff = (32'(trans_count_q) > 32'(tww_pkg::MAX_TRANSITIONS)) ?
		tww_pkg::TCW'(tww_pkg::MAX_TRANSITIONS) : tww_pkg::TCW'(trans_count_q);
	assign cur_oor  = 32'(cur_q) >= 32'(nc_eff);
	assign cur_last = (32'(cur_q) + 32'd1) == 32'(nc_eff);

	// Node memory: read own start first, the next node's start after
	assign nrd_addr = (state_q == S_ST) ? tww_pkg::NAW'(32'(cur_q) + 32'd1)
	                                    : tww_pkg::NAW'(cur_q);
	assign end_d = last_q ? tc_eff :
		((32'(nrd_q) > 32'(tc_eff)) ? tc_eff : tww_pkg::TCW'(nrd_q));

	assign nwe = acc && (mode == tww_pkg::MODE_NODE) &&
		(32'(entry_index) < 32'(tww_pkg::MAX_NODES));
	assign twe = acc && (mode == tww_pkg::MODE_TRANS) &&
		(32'(entry_index) < 32'(tww_pkg::MAX_TRANSITIONS));
	assign twr = '{symbol: symbol, target: child_node};

	always_ff @(posedge clk) begin
		if (nwe) begin
			nmem[tww_pkg::NAW'(entry_index)] <= first_child;
		end
		nrd_q <= nmem[nrd_addr];
	end

	always_ff @(posedge clk) begin
		if (twe) begin
			tmem[tww_pkg::TAW'(entry_index)] <= twr;
		end
		trd_q <= tmem[tww_pkg::TAW'(t_q)];
	end

	// Scan compare and end-of-word completion
	assign hit       = pend_q && (trd_q.symbol == key_q);
	assign more      = 32'(t_q) < 32'(end_q);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		fin       = 1'b0;
		fin_found = 1'b0;
		fin_node  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && (mode == tww_pkg::MODE_EOW) && (failed_q || cur_oor)) begin
					fin = 1'b1;
				end
			end
			S_SCAN: begin
				if (eow_q && hit) begin
					fin       = 1'b1;
					fin_found = 1'b1;
					fin_node  = trd_q.target;
				end else if (eow_q && !more) begin
					fin = 1'b1;
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	assign out_load = (fin || (state_q == S_WAIT)) && slot_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q  <= tww_pkg::NCOUNT_W'(1);
			trans_count_q <= '0;
			annot_q       <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx)
				tww_pkg::REG_NODE_COUNT:  node_count_q  <= pwdata[tww_pkg::NCOUNT_W-1:0];
				tww_pkg::REG_TRANS_COUNT: trans_count_q <= pwdata[tww_pkg::TCOUNT_W-1:0];
				tww_pkg::REG_ANNOT_SYM:   annot_q       <= pwdata[tww_pkg::SYM_W-1:0];
				default: begin
					annot_q <= annot_q;
				end
			endcase
		end
	end

	// Sequencer and walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= '0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (fin) begin
						// end of word: restart at the root, hold the result if the slot is full
						cur_q    <= '0;
						failed_q <= 1'b0;
						state_q  <= slot_free ? S_IDLE : S_WAIT;
					end else if (acc && (mode == tww_pkg::MODE_TEXT) && !failed_q) begin
						if (cur_oor) begin
							failed_q <= 1'b1;
						end else begin
							state_q <= S_ST;
						end
					end else if (acc && (mode == tww_pkg::MODE_EOW) && !failed_q && !cur_oor) begin
						state_q <= S_ST;
					end
				end
				S_ST: begin
					state_q <= S_EN;
				end
				S_EN: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (fin) begin
						// end of word: restart at the root, hold the result if the slot is full
						cur_q    <= '0;
						failed_q <= 1'b0;
						state_q  <= slot_free ? S_IDLE : S_WAIT;
					end else if (hit) begin
						cur_q   <= trd_q.target;
						state_q <= S_IDLE;
					end else if (!more) begin
						failed_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_WAIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Scan pointers, search key and result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			key_q <= (mode == tww_pkg::MODE_EOW) ? annot_q : symbol;
			eow_q <= (mode == tww_pkg::MODE_EOW);
		end
		if (state_q == S_ST) begin
			t_q    <= nrd_q;
			last_q <= cur_last;
		end
		if (state_q == S_EN) begin
			end_q  <= end_d;
			pend_q <= 1'b0;
		end
		if ((state_q == S_SCAN) && !hit && more) begin
			t_q    <= tww_pkg::FC_W'(32'(t_q) + 32'd1);
			pend_q <= 1'b1;
		end
		if (fin && !slot_free) begin
			wfound_q <= fin_found;
			wnode_q  <= fin_node;
		end
		if (out_load) begin
			found_q <= fin ? fin_found : wfound_q;
			node_q  <= fin ? fin_node : wnode_q;
		end
	end

endmodule

/* rtl/core/tww_check.sv */
`timescale 1ns / 1ps

module tww_check (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pready,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [tww_pkg::MODE_W-1:0]   mode,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         found,
	input logic [tww_pkg::NODE_W-1:0]   node_index
);

	// A waiting result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(node_index))
		else $error("result changed while stalled");

	// Not found always reports the root
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> node_index == '0)
		else $error("not-found result with nonzero node");

	// Load items never make the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (mode == tww_pkg::MODE_NODE || mode == tww_pkg::MODE_TRANS)
		|=> in_ready)
		else $error("block busy after a load item");

	// Configuration port never inserts wait states
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind trie_word_walk_unit tww_check u_tww_check (.*);
